>>> rtl/core/kncp_pkg.sv
// ----------------------------------------------------------------------------
// kncp_pkg
// Types and constants shared by the keyword/number command parser.
// ----------------------------------------------------------------------------
package kncp_pkg;

   localparam int unsigned NUM_KEYWORDS = 3;
   localparam int unsigned KW_MAX_LEN   = 8;
   localparam int unsigned POS_WIDTH    = 7;

   localparam logic [POS_WIDTH-1:0] POS_MAX  = 7'd127;
   localparam logic [7:0]           DIGIT_LO = 8'd48;
   localparam logic [7:0]           DIGIT_HI = 8'd57;

   localparam logic [1:0] CMD_LEDON    = 2'd0;
   localparam logic [1:0] CMD_LEDOFF   = 2'd1;
   localparam logic [1:0] CMD_BAUDRATE = 2'd2;

   localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KW_MAX_LEN] = '{
      '{8'h6C, 8'h65, 8'h64, 8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00},
      '{8'h6C, 8'h65, 8'h64, 8'h6F, 8'h66, 8'h66, 8'h00, 8'h00},
      '{8'h62, 8'h61, 8'h75, 8'h64, 8'h72, 8'h61, 8'h74, 8'h65}
   };

   localparam logic [POS_WIDTH-1:0] KW_LEN [NUM_KEYWORDS] = '{7'd5, 7'd6, 7'd8};

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic        cmd_valid;
      logic [1:0]  cmd_index;
      logic [31:0] cmd_value;
   } rsp_type;

   typedef struct packed {
      logic [NUM_KEYWORDS-1:0] keyword_alive;
      logic [POS_WIDTH-1:0]    byte_position;
      logic [1:0]              matched_keyword;
      logic                    keyword_done;
      logic                    digits_ok;
      logic                    digit_seen;
      logic [31:0]             value_accumulator;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      keyword_alive:     '1,
      byte_position:     '0,
      matched_keyword:   CMD_LEDON,
      keyword_done:      1'b0,
      digits_ok:         1'b1,
      digit_seen:        1'b0,
      value_accumulator: '0
   };

   function automatic logic [POS_WIDTH-1:0] kw_len_of(input logic [1:0] idx);
      logic [POS_WIDTH-1:0] len;
      unique case (idx)
         CMD_LEDON:    len = KW_LEN[0];
         CMD_LEDOFF:   len = KW_LEN[1];
         CMD_BAUDRATE: len = KW_LEN[2];
         default:      len = '0;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/core/keyword_number_command_parser_core.sv
// ----------------------------------------------------------------------------
// keyword_number_command_parser_core
// Parses "ledon", "ledoff" or "baudrate", one separator and a decimal number
// from a byte stream, one command result per packet.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one packet byte per transfer, end_of_packet set on the
//   final byte. rsp_ channel: one transfer per packet, issued for the final
//   byte, carrying cmd_valid, cmd_index and the saturated cmd_value.
//   Bytes before the final one produce no response.
// Timing:
//   One byte per cycle sustained while no final byte waits. A byte is
//   captured in an input register, processed against the parse state (in
//   the following cycle unless it is a final byte that must wait), and the
//   response is held in the output register until rsp_ready takes it.
// Stalls:
//   While rsp_valid waits for rsp_ready, non-final bytes keep flowing in;
//   a final byte waits in the input register until the output register
//   frees, and req_ready drops only while such a byte waits.
// Reset:
//   Clears both valid flags and returns the parse state to the start of a
//   packet. No clearing pass is needed.
// ----------------------------------------------------------------------------
module keyword_number_command_parser_core #(
   parameter int unsigned MAX_PACKET = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kncp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kncp_pkg::rsp_type rsp_payload
);
   import kncp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff, in_data_in;
   parse_state_type state_ff, state_in;
   parse_state_type state_step;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff, out_data_in;
   logic            proc_fire;
   logic            pkt_done;
   logic            cmd_ok;

   kncp_step #(
      .MAX_PACKET(MAX_PACKET)
   ) u_step (
      .state_cur(state_ff),
      .rx_byte  (in_data_ff.rx_byte),
      .state_nxt(state_step)
   );

   assign pkt_done  = in_data_ff.end_of_packet;
   assign proc_fire = in_valid_ff && (!pkt_done || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_fire;
   assign cmd_ok    = state_step.keyword_done && state_step.digits_ok
                    && state_step.digit_seen;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_payload;
      end

      state_in = state_ff;
      if (proc_fire) begin
         state_in = pkt_done ? STATE_RESET : state_step;
      end

      out_valid_in = out_valid_ff && !rsp_ready;
      out_data_in  = out_data_ff;
      if (proc_fire && pkt_done) begin
         out_valid_in          = 1'b1;
         out_data_in.cmd_valid = cmd_ok;
         out_data_in.cmd_index = cmd_ok ? state_step.matched_keyword : CMD_LEDON;
         out_data_in.cmd_value = cmd_ok ? state_step.value_accumulator : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.cmd_valid
      |-> (out_data_ff.cmd_index == CMD_LEDON) && (out_data_ff.cmd_value == 32'd0))
      else $error("invalid response carries nonzero index or value");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.cmd_index == CMD_LEDON)
                    || (out_data_ff.cmd_index == CMD_LEDOFF)
                    || (out_data_ff.cmd_index == CMD_BAUDRATE))
      else $error("response index out of range");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      proc_fire && pkt_done |=> (state_ff == STATE_RESET) && out_valid_ff)
      else $error("packet end did not clear state or raise response");

   a_pending_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled input byte lost");

endmodule

>>> rtl/core/kncp_step.sv
// ----------------------------------------------------------------------------
// kncp_step
// Next parse state for one packet byte: keyword match, separator skip and
// saturating decimal accumulate.
// ----------------------------------------------------------------------------
module kncp_step #(
   parameter int unsigned MAX_PACKET = 64
) (
   input  kncp_pkg::parse_state_type state_cur,
   input  logic [7:0]                rx_byte,
   output kncp_pkg::parse_state_type state_nxt
);
   import kncp_pkg::*;

   localparam logic [POS_WIDTH-1:0] MaxPos = POS_WIDTH'(MAX_PACKET);

   logic [POS_WIDTH-1:0] pos;
   logic                 is_digit;
   logic [35:0]          acc_sum;

   assign pos      = state_cur.byte_position;
   assign is_digit = (rx_byte >= DIGIT_LO) && (rx_byte <= DIGIT_HI);
   assign acc_sum  = {1'b0, state_cur.value_accumulator, 3'b000}
                   + {3'b000, state_cur.value_accumulator, 1'b0}
                   + {32'd0, 4'(rx_byte - DIGIT_LO)};

   always_comb begin
      logic found;
      state_nxt = state_cur;
      found     = 1'b0;
      if (pos >= MaxPos) begin
         state_nxt.digits_ok = 1'b0;
      end else if (!state_cur.keyword_done) begin
         for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if ((pos < KW_LEN[k]) && (rx_byte != KW_TEXT[k][pos[2:0]])) begin
               state_nxt.keyword_alive[k] = 1'b0;
            end
         end
         for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (!found && state_nxt.keyword_alive[k] && (KW_LEN[k] == pos + 7'd1)) begin
               found                     = 1'b1;
               state_nxt.keyword_done    = 1'b1;
               state_nxt.matched_keyword = 2'(k);
            end
         end
      end else if (pos == kw_len_of(state_cur.matched_keyword)) begin
         state_nxt.digits_ok = state_cur.digits_ok;
      end else if (is_digit) begin
         state_nxt.value_accumulator = (acc_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                 : acc_sum[31:0];
         state_nxt.digit_seen = 1'b1;
      end else begin
         state_nxt.digits_ok = 1'b0;
      end
      if (pos != POS_MAX) begin
         state_nxt.byte_position = pos + 7'd1;
      end
   end

endmodule

>>> tb/sv/kncp_parse_checker.sv
// ----------------------------------------------------------------------------
// kncp_parse_checker
// Watches both channels of the command parser, predicts the command result
// of each packet from the bytes transferred in, and compares every response
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module kncp_parse_checker #(
   parameter int unsigned MAX_PACKET = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  kncp_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  kncp_pkg::rsp_type rsp_payload,
   output int                mismatch_count,
   output int                pending_results
);

   import kncp_pkg::*;

   string keyword_text [3] = '{"ledon", "ledoff", "baudrate"};

   logic [2:0]  kw_alive;
   logic [6:0]  byte_pos;
   logic [1:0]  kw_match;
   logic        kw_done;
   logic        digits_ok;
   logic        digit_seen;
   logic [31:0] number_acc;

   rsp_type cmd_expect_q [$];

   task automatic clear_parse_state();
      kw_alive   = '1;
      byte_pos   = '0;
      kw_match   = CMD_LEDON;
      kw_done    = 1'b0;
      digits_ok  = 1'b1;
      digit_seen = 1'b0;
      number_acc = '0;
   endtask

   // advance the parse by one byte; on the end mark queue the command result
   task automatic parse_command_byte(input req_type item);
      rsp_type     cmd;
      logic [35:0] wide;
      logic [7:0]  digit;
      bit          hit;
      if (byte_pos >= MAX_PACKET) begin
         digits_ok = 1'b0;
      end else if (!kw_done) begin
         for (int k = 0; k < 3; k++) begin
            if (byte_pos < keyword_text[k].len() && item.rx_byte != keyword_text[k][byte_pos])
               kw_alive[k] = 1'b0;
         end
         hit = 1'b0;
         for (int k = 0; k < 3; k++) begin
            if (!hit && kw_alive[k] && keyword_text[k].len() == int'(byte_pos) + 1) begin
               hit      = 1'b1;
               kw_done  = 1'b1;
               kw_match = 2'(k);
            end
         end
      end else if (int'(byte_pos) == keyword_text[kw_match].len()) begin
         // separator byte, any value
      end else if (item.rx_byte >= DIGIT_LO && item.rx_byte <= DIGIT_HI) begin
         digit      = item.rx_byte - DIGIT_LO;
         wide       = {4'd0, number_acc} * 36'd10 + {28'd0, digit};
         number_acc = (wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : wide[31:0];
         digit_seen = 1'b1;
      end else begin
         digits_ok = 1'b0;
      end
      if (byte_pos != POS_MAX)
         byte_pos = byte_pos + 7'd1;
      if (item.end_of_packet) begin
         cmd.cmd_valid = kw_done && digits_ok && digit_seen;
         cmd.cmd_index = cmd.cmd_valid ? kw_match : CMD_LEDON;
         cmd.cmd_value = cmd.cmd_valid ? number_acc : 32'd0;
         cmd_expect_q.push_back(cmd);
         clear_parse_state();
      end
   endtask

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      clear_parse_state();
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parse_state();
         cmd_expect_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cmd_expect_q.size() == 0) begin
               $display("%0t unexpected result: expected none, got valid=%0d index=%0d value=%0d",
                        $time, rsp_payload.cmd_valid, rsp_payload.cmd_index,
                        rsp_payload.cmd_value);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = cmd_expect_q.pop_front();
               if (rsp_payload.cmd_valid !== want.cmd_valid
                   || rsp_payload.cmd_index !== want.cmd_index
                   || rsp_payload.cmd_value !== want.cmd_value) begin
                  $display({"%0t mismatch: expected valid=%0d index=%0d value=%0d,",
                            " got valid=%0d index=%0d value=%0d"},
                           $time, want.cmd_valid, want.cmd_index, want.cmd_value,
                           rsp_payload.cmd_valid, rsp_payload.cmd_index,
                           rsp_payload.cmd_value);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            parse_command_byte(req_payload);
      end
      pending_results <= cmd_expect_q.size();
   end

endmodule

>>> tb/sv/tb_keyword_number_command_parser_core.sv
// ----------------------------------------------------------------------------
// tb_keyword_number_command_parser_core
// Drives packets into the command parser: directed keyword, separator, digit,
// saturation and overlong cases first, then mostly well-formed random
// commands mixed with broken and garbage packets, under changing idle and
// stall patterns. The checker beside the block decides each transfer.
// ----------------------------------------------------------------------------
module tb_keyword_number_command_parser_core;

   import kncp_pkg::*;

   localparam int unsigned PACKET_LIMIT = 64;
   localparam int          RANDOM_BYTES = 160;
   localparam int          HANG_LIMIT   = 4000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int mismatch_count;
   int pending_results;
   int send_idle_pct;
   int recv_stall_pct;
   int bytes_sent;
   int quiet_cycles;

   string      cmd_words [3] = '{"ledon", "ledoff", "baudrate"};
   logic [7:0] packet_q [$];

   keyword_number_command_parser_core #(
      .MAX_PACKET (PACKET_LIMIT)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   kncp_parse_checker #(
      .MAX_PACKET (PACKET_LIMIT)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial rsp_ready = 1'b0;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t timeout: no transfer for %0d cycles", $time, HANG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic eop);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{rx_byte: value, end_of_packet: eop};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < packet_q.size(); i++)
         send_byte(packet_q[i], i == packet_q.size() - 1);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         packet_q.push_back(s[i]);
   endtask

   task automatic add_digits(input int n);
      for (int i = 0; i < n; i++)
         packet_q.push_back(DIGIT_LO + 8'($urandom_range(9)));
   endtask

   task automatic send_text(input string s);
      packet_q.delete();
      add_text(s);
      send_packet();
   endtask

   initial begin
      int sel;
      int cut;
      int target;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      bytes_sent     = 0;
      quiet_cycles   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed packets
      send_text("ledon 1");
      send_text("ledoff 0");
      send_text("baudrate 115200");
      send_text("baudrate 4294967295");
      send_text("baudrate 4294967296");
      send_text("ledon 99999999999999999999");
      send_text("ledo");
      send_text("ledon");
      send_text("baudrate-");
      send_text("ledon 12a3");
      send_text("ledon /");
      send_text("ledoff :");
      send_text("ledonx09");
      send_text("LEDON 5");
      send_text("x");
      packet_q.delete();
      packet_q.push_back(8'hFF);
      send_packet();
      packet_q.delete();
      add_text("ledoff");
      packet_q.push_back(8'h00);
      add_text("42");
      send_packet();
      packet_q.delete();
      add_text("baudrate");
      packet_q.push_back(8'hFF);
      add_text("9600");
      send_packet();
      // exactly at the buffer size, one past it, and far past it
      packet_q.delete();
      add_text("ledon ");
      add_digits(PACKET_LIMIT - 6);
      send_packet();
      packet_q.delete();
      add_text("ledon ");
      add_digits(PACKET_LIMIT - 5);
      send_packet();
      packet_q.delete();
      add_text("baudrate ");
      add_digits(131);
      send_packet();

      // random packets under rotating idle patterns
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         unique case ((bytes_sent * 8 / RANDOM_BYTES) % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 58;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 58;
            end
            default: begin
               send_idle_pct  = 30;
               recv_stall_pct = 30;
            end
         endcase
         packet_q.delete();
         sel = $urandom_range(99);
         if (sel < 92 && !(sel >= 83 && sel < 92)) begin
            add_text(cmd_words[$urandom_range(2)]);
            packet_q.push_back(8'($urandom_range(255)));
            if (sel < 83) begin
               add_digits(($urandom_range(9) == 0) ? $urandom_range(11, 22)
                                                   : $urandom_range(1, 10));
            end
            if (sel >= 65 && sel < 75) begin
               packet_q[$urandom_range(packet_q.size() - 1)] = 8'($urandom_range(255));
            end else if (sel >= 75 && sel < 83) begin
               cut = $urandom_range(1, packet_q.size() - 1);
               while (packet_q.size() > cut)
                  packet_q.pop_back();
            end
         end else if (sel < 92) begin
            if ($urandom_range(1))
               add_text(($urandom_range(1)) ? "led" : "baud");
            for (int i = $urandom_range(1, 12); i > 0; i--)
               packet_q.push_back(8'($urandom_range(255)));
         end else begin
            add_text(cmd_words[$urandom_range(2)]);
            packet_q.push_back(8'($urandom_range(255)));
            target = ($urandom_range(4) == 0) ? $urandom_range(120, 140)
                                              : $urandom_range(PACKET_LIMIT - 4,
                                                               PACKET_LIMIT + 6);
            add_digits(target - packet_q.size());
            if ($urandom_range(3) == 0)
               packet_q[$urandom_range(packet_q.size() - 1)] = 8'($urandom_range(255));
         end
         send_packet();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
